/* rtl/mlq_pkg.sv */
// Shared types, codes and sizing constants of the multilevel-queue task picker.
`default_nettype none
package mlq_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int RANK_W      = 52;
	localparam int CFG_IDX_W   = 3;

	localparam logic [RANK_W-1:0] RANK_LIMIT = RANK_W'(64'd5120000000);

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_ASSIGN = 2'd1,
		OP_PICK   = 2'd2,
		OP_AGE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		Q_RR    = 2'd0,
		Q_LCFS  = 2'd1,
		Q_BJF   = 2'd2,
		Q_UNSET = 2'd3
	} queue_t;

	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_PRIO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_ARR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_EXEC = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AGING      = 3'd4;

	typedef struct packed {
		logic [15:0] rp;
		logic [15:0] ra;
		logic [15:0] re;
		logic [15:0] rs;
	} ratios_t;

	typedef struct packed {
		logic        runnable;
		logic [1:0]  queue;
		logic [31:0] queue_arrival;
		logic [31:0] run_stamp;
		logic [7:0]  priority_v;
		logic [15:0] arrival;
		logic [31:0] exec_tenths;
		logic [30:0] size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* rtl/mlq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/mlq_rank.sv */
// Best-job-first rank unit: four products through one shared 32x16 multiplier.
`default_nettype none
module mlq_rank (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [7:0]                    prio,
	input  wire logic [15:0]                   arr,
	input  wire logic [31:0]                   exec_tenths,
	input  wire logic [30:0]                   size,
	input  wire mlq_pkg::ratios_t              ratios,
	output logic                               done,
	output logic      [mlq_pkg::RANK_W-1:0]    rank
);
	import mlq_pkg::*;

	logic [2:0]        cnt_q;
	logic              busy_q;
	logic              exec_term_q;
	logic [47:0]       prod_q;
	logic [RANK_W-1:0] acc_q;
	logic [7:0]        prio_q;
	logic [15:0]       arr_q;
	logic [31:0]       exec_q;
	logic [30:0]       size_q;
	logic [31:0]       a_op;
	logic [15:0]       b_op;
	logic [47:0]       mul;
	logic [RANK_W-1:0] p_ext;
	logic [RANK_W-1:0] term;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin a_op = {24'd0, prio_q}; b_op = ratios.rp; end
			2'd1: begin a_op = {16'd0, arr_q};  b_op = ratios.ra; end
			2'd2: begin a_op = exec_q;          b_op = ratios.re; end
			default: begin a_op = {1'b0, size_q}; b_op = ratios.rs; end
		endcase
		mul   = 48'(a_op) * 48'(b_op);
		p_ext = RANK_W'(prod_q);
		// times ten for every term but the executed count, already in tenths
		term  = exec_term_q ? p_ext : (p_ext << 3) + (p_ext << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
				prio_q <= prio;
				arr_q  <= arr;
				exec_q <= exec_tenths;
				size_q <= size;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					prod_q      <= mul;
					exec_term_q <= (cnt_q == 3'd2);
				end
				if (cnt_q != 3'd0) begin
					acc_q <= acc_q + term;
				end
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	assign rank = acc_q;
endmodule
`default_nettype wire

/* rtl/multilevel_queue_task_picker.sv */
// Top level of the multilevel-queue task picker: table sequencer, result register, config.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  in      | in_valid / in_ready    | operation slot runnable queue_req pid priority_req
//          |                        | arrival_stamp task_size now
//  out     | out_valid / out_ready  | picked picked_slot picked_class prev_class error
//          |                        | moved_count
//  cfg     | cfg_we                 | cfg_index cfg_data
//
// One transaction at a time; the table sits in one RAM and each row is read (S_RD), then
// evaluated (S_EV). Write entry and assign queue touch one row, age scan every row. Pick
// visits slots in the round-robin, last-come and best-job-first passes; each best-job-first
// candidate waits on the shared rank unit, then the picked row is read and updated.
// Reset marks every row invalid at once (an invalid row reads as zero); no clearing pass.
// A finished result waits in the output register; in_ready rises again once it is loaded.
`default_nettype none
module multilevel_queue_task_picker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     operation,
	input  wire logic [5:0]                     slot,
	input  wire logic                           runnable,
	input  wire logic [1:0]                     queue_req,
	input  wire logic signed [15:0]             pid,
	input  wire logic [7:0]                     priority_req,
	input  wire logic [15:0]                    arrival_stamp,
	input  wire logic [30:0]                    task_size,
	input  wire logic [31:0]                    now,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                picked,
	output logic      [5:0]                     picked_slot,
	output logic      [1:0]                     picked_class,
	output logic      [1:0]                     prev_class,
	output logic                                error,
	output logic      [6:0]                     moved_count,
	input  wire logic                           cfg_we,
	input  wire logic [mlq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import mlq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_RANK,
		S_FIX_RD,
		S_FIX_WB,
		S_DONE
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
	localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);

	state_t            state_q;
	ratios_t           ratios_q;
	logic [31:0]       aging_q;

	// latched transaction
	op_t               op_q;
	logic              run_q;
	logic [1:0]        nq_q;
	logic [7:0]        prio_q;
	logic [15:0]       arr_q;
	logic [30:0]       size_q;
	logic [31:0]       now_q;

	// scan state
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	queue_t            class_q;
	logic              found_q;
	logic [SLOT_W-1:0] best_q;
	logic [31:0]       best_qarr_q;
	logic [RANK_W-1:0] best_rank_q;
	logic [SLOT_W-1:0] rr_last_q;
	logic [CNT_W-1:0]  moved_q;

	// pending result
	logic              res_picked_q;
	logic [1:0]        res_class_q;
	logic [1:0]        res_old_q;
	logic              res_err_q;

	logic [TABLE_SLOTS-1:0] row_valid_q;
	logic                   rvld_q;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            row;

	logic              rank_start;
	logic              rank_done;
	logic [RANK_W-1:0] rank;

	logic              accept;
	logic              out_load;
	logic              in_range;
	logic [1:0]        nq_res;
	logic              nq_err;
	logic              cand;
	logic              promote;
	logic [SLOT_W-1:0] idx_next;

	mlq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mlq_rank u_rank (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (rank_start),
		.prio        (row.priority_v),
		.arr         (row.arrival),
		.exec_tenths (row.exec_tenths),
		.size        (row.size),
		.ratios      (ratios_q),
		.done        (rank_done),
		.rank        (rank)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// load the result once the output register is free
	assign out_load = (state_q == S_DONE) && (!out_valid || out_ready);
	assign in_range = ({26'd0, slot} < 32'(TABLE_SLOTS));
	assign idx_next = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	// resolve the unset class from the pid
	always_comb begin
		nq_res = queue_req;
		nq_err = 1'b0;
		if (queue_req == Q_UNSET) begin
			if (pid == 16'sd1) begin
				nq_res = Q_RR;
			end else if (pid > 16'sd1) begin
				nq_res = Q_LCFS;
			end else begin
				nq_err = 1'b1;
			end
		end
	end

	// a row never written reads as its reset value, all zero
	always_comb begin
		row = rvld_q ? entry_t'(ram_rdata) : '0;
	end

	always_comb begin
		cand    = row.runnable && (row.queue == class_q);
		promote = row.runnable && (row.queue != Q_RR) && ((now_q - row.run_stamp) > aging_q);
	end

	// table port drive
	always_comb begin
		ram_re     = 1'b0;
		ram_raddr  = idx_q;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = row;
		rank_start = 1'b0;
		unique case (state_q)
			S_RD: begin
				ram_re = 1'b1;
			end
			S_FIX_RD: begin
				ram_re    = 1'b1;
				ram_raddr = best_q;
			end
			S_EV: begin
				unique case (op_q)
					OP_WRITE: begin
						ram_we               = 1'b1;
						ram_wdata.runnable   = run_q;
						ram_wdata.priority_v = prio_q;
						ram_wdata.arrival    = arr_q;
						ram_wdata.size       = size_q;
					end
					OP_ASSIGN: begin
						ram_we                  = 1'b1;
						ram_wdata.queue         = nq_q;
						ram_wdata.queue_arrival = now_q;
					end
					OP_AGE: begin
						ram_we                  = promote;
						ram_wdata.queue         = Q_RR;
						ram_wdata.queue_arrival = now_q;
					end
					OP_PICK: begin
						rank_start = cand && (class_q == Q_BJF);
					end
					default: begin
					end
				endcase
			end
			S_FIX_WB: begin
				ram_we                = 1'b1;
				ram_waddr             = best_q;
				ram_wdata.runnable    = 1'b0;
				ram_wdata.run_stamp   = now_q;
				ram_wdata.exec_tenths = (&row.exec_tenths) ? row.exec_tenths
				                                           : row.exec_tenths + 32'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ratios_q    <= '{rp: 16'd256, ra: 16'd256, re: 16'd256, rs: 16'd256};
			aging_q     <= 32'd8000;
			rr_last_q   <= LAST_SLOT;
			row_valid_q <= '0;
			rvld_q      <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			// configuration is to arrive only while idle; the user must keep to this, the block does not enforce it
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RATIO_PRIO: ratios_q.rp <= cfg_data[15:0];
					CFG_RATIO_ARR:  ratios_q.ra <= cfg_data[15:0];
					CFG_RATIO_EXEC: ratios_q.re <= cfg_data[15:0];
					CFG_RATIO_SIZE: ratios_q.rs <= cfg_data[15:0];
					CFG_AGING:      aging_q     <= cfg_data;
					default: begin
					end
				endcase
			end

			if (ram_re) begin
				rvld_q <= row_valid_q[ram_raddr];
			end
			if (ram_we) begin
				row_valid_q[ram_waddr] <= 1'b1;
			end

			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= op_t'(operation);
						run_q        <= runnable;
						nq_q         <= nq_res;
						prio_q       <= priority_req;
						arr_q        <= arrival_stamp;
						size_q       <= task_size;
						now_q        <= now;
						res_picked_q <= 1'b0;
						res_class_q  <= Q_RR;
						res_old_q    <= Q_RR;
						res_err_q    <= 1'b0;
						found_q      <= 1'b0;
						moved_q      <= '0;
						cnt_q        <= '0;
						best_q       <= '0;
						best_rank_q  <= RANK_LIMIT;
						class_q      <= Q_RR;
						unique case (op_t'(operation))
							OP_WRITE: begin
								idx_q   <= SLOT_W'(slot);
								state_q <= in_range ? S_RD : S_DONE;
							end
							OP_ASSIGN: begin
								idx_q     <= SLOT_W'(slot);
								res_err_q <= in_range && nq_err;
								state_q   <= (in_range && !nq_err) ? S_RD : S_DONE;
							end
							OP_PICK: begin
								// continue after the last round-robin pick
								idx_q   <= (rr_last_q == LAST_SLOT) ? '0 : rr_last_q + 1'b1;
								state_q <= S_RD;
							end
							default: begin
								idx_q   <= '0;
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					unique case (op_q)
						OP_WRITE: begin
							state_q <= S_DONE;
						end
						OP_ASSIGN: begin
							res_old_q <= row.queue;
							state_q   <= S_DONE;
						end
						OP_AGE: begin
							if (promote) begin
								moved_q <= moved_q + 1'b1;
							end
							idx_q   <= idx_next;
							state_q <= (idx_q == LAST_SLOT) ? S_DONE : S_RD;
						end
						default: begin
							if (class_q == Q_RR) begin
								if (cand) begin
									best_q    <= idx_q;
									rr_last_q <= idx_q;
									state_q   <= S_FIX_RD;
								end else if (cnt_q == LAST_CNT) begin
									class_q <= Q_LCFS;
									idx_q   <= '0;
									state_q <= S_RD;
								end else begin
									cnt_q   <= cnt_q + 1'b1;
									idx_q   <= idx_next;
									state_q <= S_RD;
								end
							end else if (class_q == Q_LCFS) begin
								// strictly newer arrival wins; first slot on ties
								if (cand && (!found_q || (best_qarr_q < row.queue_arrival))) begin
									best_q      <= idx_q;
									best_qarr_q <= row.queue_arrival;
									found_q     <= 1'b1;
								end
								if (idx_q == LAST_SLOT) begin
									if (found_q || cand) begin
										state_q <= S_FIX_RD;
									end else begin
										class_q <= Q_BJF;
										idx_q   <= '0;
										state_q <= S_RD;
									end
								end else begin
									idx_q   <= idx_next;
									state_q <= S_RD;
								end
							end else begin
								if (cand) begin
									state_q <= S_RANK;
								end else if (idx_q == LAST_SLOT) begin
									state_q <= found_q ? S_FIX_RD : S_DONE;
								end else begin
									idx_q   <= idx_next;
									state_q <= S_RD;
								end
							end
						end
					endcase
				end
				S_RANK: begin
					if (rank_done) begin
						if (rank < best_rank_q) begin
							best_rank_q <= rank;
							best_q      <= idx_q;
							found_q     <= 1'b1;
						end
						if (idx_q == LAST_SLOT) begin
							state_q <= (found_q || (rank < best_rank_q)) ? S_FIX_RD : S_DONE;
						end else begin
							idx_q   <= idx_next;
							state_q <= S_RD;
						end
					end
				end
				S_FIX_RD: begin
					state_q <= S_FIX_WB;
				end
				S_FIX_WB: begin
					res_picked_q <= 1'b1;
					res_class_q  <= class_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						picked       <= res_picked_q;
						picked_slot  <= res_picked_q ? 6'(best_q) : 6'd0;
						picked_class <= res_picked_q ? res_class_q : Q_RR;
						prev_class   <= res_old_q;
						error        <= res_err_q;
						moved_count  <= 7'(moved_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while a transaction is in flight");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_EV) || (state_q == S_FIX_WB))
		else $error("table written outside evaluation or write-back");

	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !picked |-> (picked_slot == 6'd0) && (picked_class == Q_RR))
		else $error("no pick but slot or class non-zero");
`endif

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench of the multilevel-queue task picker with a built-in predictor.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mlq_pkg::*;

	typedef struct packed {
		op_t         op;
		logic [5:0]  slot;
		logic        runnable;
		queue_t      nq;
		logic [15:0] pid;
		logic [7:0]  prio;
		logic [15:0] arr;
		logic [30:0] size;
		logic [31:0] now;
	} task_op_t;

	typedef struct packed {
		logic       picked;
		logic [5:0] picked_slot;
		logic [1:0] picked_class;
		logic [1:0] prev_class;
		logic       error;
		logic [6:0] moved_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic       picked;
	logic [5:0] picked_slot;
	logic [1:0] picked_class;
	logic [1:0] prev_class;
	logic       error;
	logic [6:0] moved_count;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	task_op_t cur_op = '0;
	outcome_t got;

	// Shadow of the scheduler state, kept in step with every accepted transaction.
	logic        tbl_run [TABLE_SLOTS];
	logic [1:0]  tbl_queue [TABLE_SLOTS];
	logic [31:0] tbl_qarr [TABLE_SLOTS];
	logic [31:0] tbl_last [TABLE_SLOTS];
	logic [7:0]  tbl_prio [TABLE_SLOTS];
	logic [15:0] tbl_arr [TABLE_SLOTS];
	logic [31:0] tbl_exec [TABLE_SLOTS];
	logic [30:0] tbl_size [TABLE_SLOTS];
	logic [5:0]  rr_cursor;
	logic [15:0] w_prio, w_arr, w_exec, w_size;
	logic [31:0] age_limit;

	task_op_t pending_ops[$];
	outcome_t expected_outcomes[$];
	int  errors = 0;
	bit  calm = 1'b0;       // last part of the run: no idling
	bit  hold_off = 1'b0;   // long receiver stall to fill the block
	int  drv_gap = 0;
	int  mon_gap = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	multilevel_queue_task_picker i_dut (
		.clk, .arst_n, .in_valid, .in_ready,
		.operation(cur_op.op), .slot(cur_op.slot), .runnable(cur_op.runnable),
		.queue_req(cur_op.nq), .pid(cur_op.pid), .priority_req(cur_op.prio),
		.arrival_stamp(cur_op.arr), .task_size(cur_op.size), .now(cur_op.now),
		.out_valid, .out_ready, .picked, .picked_slot, .picked_class,
		.prev_class, .error, .moved_count, .cfg_we, .cfg_index, .cfg_data
	);

	function automatic logic [63:0] bjf_rank(int s);
		logic [63:0] r;
		r = 64'(10) * tbl_prio[s] * w_prio;
		r += 64'(10) * tbl_arr[s] * w_arr;
		r += 64'(tbl_exec[s]) * w_exec;
		r += 64'(10) * tbl_size[s] * w_size;
		return r;
	endfunction

	// Apply one transaction to the shadow state and return the outcome it should give.
	function automatic outcome_t schedule_step(task_op_t t);
		outcome_t o;
		int s, idx, best;
		bit found;
		logic [63:0] best_rank, r;
		logic [1:0] q;
		o = '0;
		found = 1'b0;
		best = 0;
		case (t.op)
			OP_WRITE: begin
				tbl_run[t.slot] = t.runnable;
				tbl_prio[t.slot] = t.prio;
				tbl_arr[t.slot] = t.arr;
				tbl_size[t.slot] = t.size;
			end
			OP_ASSIGN: begin
				q = t.nq;
				if (t.nq == Q_UNSET) begin
					if ($signed(t.pid) == 1) q = Q_RR;
					else if ($signed(t.pid) > 1) q = Q_LCFS;
					else begin
						o.error = 1'b1;
						return o;
					end
				end
				o.prev_class = tbl_queue[t.slot];
				tbl_queue[t.slot] = q;
				tbl_qarr[t.slot] = t.now;
			end
			OP_PICK: begin
				idx = rr_cursor;
				for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
					idx = (idx + 1) % TABLE_SLOTS;
					if (tbl_run[idx] && tbl_queue[idx] == Q_RR) begin
						found = 1'b1;
						best = idx;
						rr_cursor = idx;
						o.picked_class = Q_RR;
					end
				end
				if (!found)
					for (s = 0; s < TABLE_SLOTS; s++)
						if (tbl_run[s] && tbl_queue[s] == Q_LCFS &&
								(!found || tbl_qarr[best] < tbl_qarr[s])) begin
							best = s;
							found = 1'b1;
							o.picked_class = Q_LCFS;
						end
				if (!found) begin
					best_rank = 64'd5120000000;
					for (s = 0; s < TABLE_SLOTS; s++)
						if (tbl_run[s] && tbl_queue[s] == Q_BJF) begin
							r = bjf_rank(s);
							if (r < best_rank) begin
								best_rank = r;
								best = s;
								found = 1'b1;
								o.picked_class = Q_BJF;
							end
						end
				end
				if (found) begin
					tbl_run[best] = 1'b0;
					tbl_last[best] = t.now;
					if (tbl_exec[best] != 32'hFFFF_FFFF) tbl_exec[best]++;
					o.picked = 1'b1;
					o.picked_slot = 6'(best);
				end
			end
			default: begin
				for (s = 0; s < TABLE_SLOTS; s++)
					if (tbl_run[s] && tbl_queue[s] != Q_RR &&
							32'(t.now - tbl_last[s]) > age_limit) begin
						tbl_queue[s] = Q_RR;
						tbl_qarr[s] = t.now;
						o.moved_count++;
					end
			end
		endcase
		return o;
	endfunction

	// Driver: present queued items, idle in random bursts between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_outcomes.push_back(schedule_step(cur_op));
				if (!calm && $urandom_range(0, 5) == 0) drv_gap = $urandom_range(1, 16);
			end
			if (!(in_valid && !in_ready)) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					cur_op <= pending_ops.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{picked, picked_slot, picked_class, prev_class, error, moved_count};
				if (expected_outcomes.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = expected_outcomes.pop_front();
					if (got.picked !== e.picked) begin
						$error("picked exp %0d got %0d", e.picked, got.picked); errors++;
					end
					if (got.picked_slot !== e.picked_slot) begin
						$error("picked_slot exp %0d got %0d", e.picked_slot, got.picked_slot);
						errors++;
					end
					if (got.picked_class !== e.picked_class) begin
						$error("picked_class exp %0d got %0d", e.picked_class,
							got.picked_class);
						errors++;
					end
					if (got.prev_class !== e.prev_class) begin
						$error("prev_class exp %0d got %0d", e.prev_class, got.prev_class);
						errors++;
					end
					if (got.error !== e.error) begin
						$error("error exp %0d got %0d", e.error, got.error); errors++;
					end
					if (got.moved_count !== e.moved_count) begin
						$error("moved_count exp %0d got %0d", e.moved_count, got.moved_count);
						errors++;
					end
				end
				if (!calm && $urandom_range(0, 5) == 0) mon_gap = $urandom_range(1, 16);
			end
			if (hold_off) out_ready <= 1'b0;
			else if (mon_gap > 0) begin
				mon_gap--;
				out_ready <= 1'b0;
			end else out_ready <= 1'b1;
		end
	end

	function automatic task_op_t blank_op(op_t op, int s, logic [31:0] t);
		task_op_t x;
		x = '0;
		x.op = op;
		x.slot = 6'(s);
		x.now = t;
		x.nq = Q_RR;
		return x;
	endfunction

	function automatic task_op_t make_write(int s, bit r, logic [7:0] p, logic [15:0] a,
			logic [30:0] z, logic [31:0] t);
		task_op_t x;
		x = blank_op(OP_WRITE, s, t);
		x.runnable = r;
		x.prio = p;
		x.arr = a;
		x.size = z;
		return x;
	endfunction

	function automatic task_op_t make_assign(int s, queue_t q, logic [15:0] id,
			logic [31:0] t);
		task_op_t x;
		x = blank_op(OP_ASSIGN, s, t);
		x.nq = q;
		x.pid = id;
		return x;
	endfunction

	// Random item, biased towards filling the table with runnable tasks.
	function automatic task_op_t random_op(logic [31:0] t);
		task_op_t x;
		int k;
		k = $urandom_range(0, 99);
		x = '0;
		x.op = (k < 35) ? OP_WRITE : (k < 55) ? OP_ASSIGN : (k < 90) ? OP_PICK : OP_AGE;
		x.slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
		x.runnable = ($urandom_range(0, 4) != 0);
		x.nq = queue_t'($urandom_range(0, 3));
		x.pid = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3));
		x.prio = 8'($urandom);
		x.arr = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 50));
		x.size = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 9999));
		x.now = ($urandom_range(0, 9) == 0) ? 32'($urandom) : t;
		return x;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RATIO_PRIO: w_prio = val[15:0];
			CFG_RATIO_ARR:  w_arr = val[15:0];
			CFG_RATIO_EXEC: w_exec = val[15:0];
			CFG_RATIO_SIZE: w_size = val[15:0];
			default:        age_limit = val;
		endcase
	endtask

	// Every item returns a result, so an empty expectation queue means idle.
	task automatic drain;
		wait (pending_ops.size() == 0 && !in_valid);
		@(posedge clk);
		wait (expected_outcomes.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [31:0] clock_now;
		for (int s = 0; s < TABLE_SLOTS; s++) begin
			tbl_run[s] = '0; tbl_queue[s] = '0; tbl_qarr[s] = '0; tbl_last[s] = '0;
			tbl_prio[s] = '0; tbl_arr[s] = '0; tbl_exec[s] = '0; tbl_size[s] = '0;
		end
		rr_cursor = 6'(TABLE_SLOTS - 1);
		w_prio = 16'd256; w_arr = 16'd256; w_exec = 16'd256; w_size = 16'd256;
		age_limit = 32'd8000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pick and age, extremes, every class, unset mapping and errors.
		pending_ops.push_back(blank_op(OP_PICK, 0, 0));
		pending_ops.push_back(blank_op(OP_AGE, 0, 0));
		pending_ops.push_back(make_write(63, 1, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF, 1));
		pending_ops.push_back(make_write(0, 1, 0, 0, 0, 2));
		pending_ops.push_back(make_write(5, 1, 3, 7, 100, 3));
		pending_ops.push_back(make_assign(63, Q_BJF, 16'h7FFF, 4));
		pending_ops.push_back(make_assign(0, Q_BJF, 0, 5));
		pending_ops.push_back(make_assign(5, Q_UNSET, 16'd2, 6));
		pending_ops.push_back(make_assign(7, Q_UNSET, 16'd0, 7));
		pending_ops.push_back(make_assign(7, Q_UNSET, 16'h8000, 8));
		pending_ops.push_back(make_assign(7, Q_UNSET, 16'hFFFF, 9));
		pending_ops.push_back(make_write(7, 1, 1, 1, 1, 10));
		pending_ops.push_back(make_assign(7, Q_UNSET, 16'd1, 11));
		pending_ops.push_back(make_write(9, 1, 1, 1, 1, 12));
		pending_ops.push_back(make_assign(9, Q_LCFS, 16'd5, 6));
		for (int i = 0; i < 5; i++)
			pending_ops.push_back(blank_op(OP_PICK, 0, 32'hFFFF_FFF0 + i));
		pending_ops.push_back(make_write(5, 1, 0, 0, 0, 20));
		pending_ops.push_back(make_write(0, 1, 0, 0, 0, 20));
		pending_ops.push_back(blank_op(OP_AGE, 0, 32'hFFFF_FFFF));
		pending_ops.push_back(blank_op(OP_PICK, 0, 21));
		drain();

		// Extreme weights and a zero aging limit, then random items in phases.
		cfg_write(CFG_RATIO_PRIO, 32'hFFFF);
		cfg_write(CFG_RATIO_ARR, 32'h0000);
		cfg_write(CFG_RATIO_EXEC, 32'hFFFF);
		cfg_write(CFG_RATIO_SIZE, 32'h0000);
		cfg_write(CFG_AGING, 32'h0);
		clock_now = 32'd100;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 1) begin
				cfg_write(CFG_RATIO_PRIO, 32'($urandom_range(0, 65535)));
				cfg_write(CFG_RATIO_ARR, 32'($urandom_range(0, 65535)));
				cfg_write(CFG_RATIO_EXEC, 32'($urandom_range(0, 65535)));
				cfg_write(CFG_RATIO_SIZE, 32'($urandom_range(0, 3)));
				cfg_write(CFG_AGING, 32'hFFFF_FFFF);
			end else if (phase == 2) begin
				cfg_write(CFG_RATIO_SIZE, 32'h0);
				cfg_write(CFG_AGING, 32'd300);
				// hold the receiver while items keep coming
				hold_off = 1'b1;
			end else if (phase == 3) begin
				cfg_write(CFG_RATIO_PRIO, 32'd256);
				cfg_write(CFG_RATIO_ARR, 32'd256);
				cfg_write(CFG_RATIO_EXEC, 32'd256);
				cfg_write(CFG_RATIO_SIZE, 32'd256);
				cfg_write(CFG_AGING, 32'd8000);
				calm = 1'b1;
			end
			for (int i = 0; i < 150; i++) begin
				clock_now += $urandom_range(0, 400);
				pending_ops.push_back(random_op(clock_now));
			end
			if (hold_off) begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
